// ===== src/complex_fir_matched_filter_macros.svh =====
// ----------------------------------------------------------------------------
// Complex FIR matched filter assertion macros
// Concurrent property shorthands on i_clk with i_rst_n as disable.
// ----------------------------------------------------------------------------
`ifndef COMPLEX_FIR_MATCHED_FILTER_MACROS_SVH
`define COMPLEX_FIR_MATCHED_FILTER_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define CFIR_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define CFIR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/cfir_pkg.sv =====
// ----------------------------------------------------------------------------
// Complex FIR matched filter package
// Widths, pipeline geometry and payload types shared by the filter files.
// ----------------------------------------------------------------------------
package cfir_pkg;

    localparam int NUM_TAPS     = 8;
    localparam int SAMPLE_WIDTH = 16;
    localparam int TAP_W        = 16;
    localparam int CFG_W        = 2 * TAP_W;
    localparam int CFG_IDX_W    = 3;
    localparam int FRAC_BITS    = SAMPLE_WIDTH - 1;
    localparam int PROD_W       = TAP_W + SAMPLE_WIDTH + 1;
    localparam int TREE_LVLS    = (NUM_TAPS > 1) ? $clog2(NUM_TAPS) : 1;
    localparam int LEAVES       = 1 << TREE_LVLS;
    localparam int ACC_W        = PROD_W + TREE_LVLS;
    localparam int PIPE_STAGES  = TREE_LVLS + 3;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] re;
        logic signed [SAMPLE_WIDTH-1:0] im;
    } t_smp;

    typedef struct packed {
        logic signed [TAP_W-1:0] re;
        logic signed [TAP_W-1:0] im;
    } t_tap;

    typedef struct packed {
        logic signed [PROD_W-1:0] re;
        logic signed [PROD_W-1:0] im;
    } t_prod;

    typedef struct packed {
        logic signed [ACC_W-1:0] re;
        logic signed [ACC_W-1:0] im;
    } t_acc;

    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctl;

endpackage

// ===== src/cfir_intf.sv =====
// ----------------------------------------------------------------------------
// Complex FIR matched filter stream interfaces
// Valid/ready channels for input samples and filtered results.
// ----------------------------------------------------------------------------
interface cfir_in_if import cfir_pkg::*; ();
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_re;
    logic signed [SAMPLE_WIDTH-1:0] sample_im;

    modport source (output valid, output sample_re, output sample_im, input ready);
    modport sink   (input valid, input sample_re, input sample_im, output ready);
endinterface

interface cfir_out_if import cfir_pkg::*; ();
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] filtered_re;
    logic signed [SAMPLE_WIDTH-1:0] filtered_im;
    logic                           saturated;

    modport source (output valid, output filtered_re, output filtered_im,
                    output saturated, input ready);
    modport sink   (input valid, input filtered_re, input filtered_im,
                    input saturated, output ready);
endinterface

// ===== src/cfir_cell.sv =====
// ----------------------------------------------------------------------------
// Complex FIR tap cell
// Holds one delay-line sample, passes it on, and forms its complex product.
// ----------------------------------------------------------------------------
module cfir_cell import cfir_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_tap      i_tap,
    input  t_smp      i_smp,
    output t_smp      o_smp,
    output t_prod     o_prod
);

    t_smp  r_smp;
    t_prod r_prod;
    t_prod n_prod;

    logic signed [TAP_W+SAMPLE_WIDTH-1:0] w_rr;
    logic signed [TAP_W+SAMPLE_WIDTH-1:0] w_ii;
    logic signed [TAP_W+SAMPLE_WIDTH-1:0] w_ri;
    logic signed [TAP_W+SAMPLE_WIDTH-1:0] w_ir;

    always_comb begin
        w_rr      = i_tap.re * r_smp.re;
        w_ii      = i_tap.im * r_smp.im;
        w_ri      = i_tap.re * r_smp.im;
        w_ir      = i_tap.im * r_smp.re;
        n_prod.re = PROD_W'(w_rr) - PROD_W'(w_ii);
        n_prod.im = PROD_W'(w_ri) + PROD_W'(w_ir);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smp <= '0;
        end else if (i_ctl.shift) begin
            r_smp <= i_smp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_prod <= n_prod;
        end
    end

    assign o_smp  = r_smp;
    assign o_prod = r_prod;

endmodule

// ===== src/cfir_tree.sv =====
// ----------------------------------------------------------------------------
// Complex FIR adder tree
// Registered pairwise sum of the cell products, one tree level per stage.
// ----------------------------------------------------------------------------
module cfir_tree import cfir_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_prod i_prod [NUM_TAPS],
    input  logic  i_vld,
    input  logic  i_take,
    output logic  o_ready,
    output logic  o_vld,
    output t_acc  o_sum
);

    logic signed [ACC_W-1:0] r_re [1:LEAVES-1];
    logic signed [ACC_W-1:0] r_im [1:LEAVES-1];
    logic signed [ACC_W-1:0] w_re [1:2*LEAVES-1];
    logic signed [ACC_W-1:0] w_im [1:2*LEAVES-1];
    logic [TREE_LVLS-1:0]    r_vld;
    logic [TREE_LVLS-1:0]    w_en;

    always_comb begin
        w_en[0] = !r_vld[0] || i_take;
        for (int d = 1; d < TREE_LVLS; d++) begin
            w_en[d] = !r_vld[d] || w_en[d-1];
        end
    end

    for (genvar j = 1; j < 2 * LEAVES; j++) begin : g_wire
        if (j < LEAVES) begin : g_node
            assign w_re[j] = r_re[j];
            assign w_im[j] = r_im[j];
        end else if (j - LEAVES < NUM_TAPS) begin : g_leaf
            assign w_re[j] = ACC_W'(i_prod[j-LEAVES].re);
            assign w_im[j] = ACC_W'(i_prod[j-LEAVES].im);
        end else begin : g_pad
            assign w_re[j] = '0;
            assign w_im[j] = '0;
        end
    end

    for (genvar i = 1; i < LEAVES; i++) begin : g_sum
        localparam int D = $clog2(i + 1) - 1;
        always_ff @(posedge i_clk) begin
            if (w_en[D]) begin
                r_re[i] <= w_re[2*i] + w_re[2*i+1];
                r_im[i] <= w_im[2*i] + w_im[2*i+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[TREE_LVLS-1]) begin
                r_vld[TREE_LVLS-1] <= i_vld;
            end
            for (int d = 0; d < TREE_LVLS - 1; d++) begin
                if (w_en[d]) begin
                    r_vld[d] <= r_vld[d+1];
                end
            end
        end
    end

    assign o_ready  = w_en[TREE_LVLS-1];
    assign o_vld    = r_vld[0];
    assign o_sum.re = w_re[1];
    assign o_sum.im = w_im[1];

endmodule

// ===== src/complex_fir_matched_filter.sv =====
// ----------------------------------------------------------------------------
// Complex FIR matched filter
// Streaming complex FIR with up to eight configurable Q1.15 taps.
// ----------------------------------------------------------------------------
// Takes one complex Q1.15 sample per clock and returns one filtered sample
// per input, y[n] = sum of tap[k] * x[n-k], rounded half up, scaled by 2^-15
// and saturated per component, with a flag when either part clips. Each tap
// has its own cell with a complex multiplier, and the products meet in a
// registered adder tree, so a new sample enters every cycle that the output
// side is not holding back. The edge that accepts a sample loads the delay
// line, then come the product, three tree levels and the output register.
// The delay line resets to zero. Tap registers are written by index 0..7,
// real part in the upper 16 bits, and should be changed only while no
// samples are in flight.
// ----------------------------------------------------------------------------
module complex_fir_matched_filter import cfir_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    cfir_in_if.sink              i_smp,
    cfir_out_if.source           o_flt,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] SAT_MAX  = ACC_W'((1 << (SAMPLE_WIDTH - 1)) - 1);
    localparam logic signed [ACC_W-1:0] SAT_MIN  = ~SAT_MAX;

    function automatic logic [SAMPLE_WIDTH:0] round_sat(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] rnd;
        logic signed [ACC_W-1:0] q;
        logic [SAMPLE_WIDTH:0]   res;
        rnd = v + RND_HALF;
        q   = rnd >>> FRAC_BITS;
        if (q > SAT_MAX) begin
            res = {1'b1, SAT_MAX[SAMPLE_WIDTH-1:0]};
        end else if (q < SAT_MIN) begin
            res = {1'b1, SAT_MIN[SAMPLE_WIDTH-1:0]};
        end else begin
            res = {1'b0, q[SAMPLE_WIDTH-1:0]};
        end
        return res;
    endfunction

    t_tap      r_tap [NUM_TAPS];
    t_smp      w_chain [NUM_TAPS];
    t_prod     w_prod [NUM_TAPS];
    t_cell_ctl w_ctl;
    t_acc      w_sum;

    logic r_v0;
    logic r_v1;
    logic w_en0;
    logic w_en1;
    logic w_en_out;
    logic w_tree_ready;
    logic w_tree_vld;
    logic w_accept;

    logic [SAMPLE_WIDTH:0] w_res_re;
    logic [SAMPLE_WIDTH:0] w_res_im;

    logic                           r_out_vld;
    logic signed [SAMPLE_WIDTH-1:0] r_out_re;
    logic signed [SAMPLE_WIDTH-1:0] r_out_im;
    logic                           r_out_sat;

    // tap registers
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NUM_TAPS; k++) begin
            if (!i_rst_n) begin
                r_tap[k] <= '0;
            end else if (i_cfg_we && i_cfg_idx == CFG_IDX_W'(k)) begin
                r_tap[k] <= t_tap'(i_cfg_data);
            end
        end
    end

    // stall chain, output side first
    assign w_en_out = !r_out_vld || o_flt.ready;
    assign w_en1    = !r_v1 || w_tree_ready;
    assign w_en0    = !r_v0 || w_en1;
    assign w_accept = i_smp.valid && w_en0;

    assign i_smp.ready = w_en0;
    assign w_ctl.shift = w_accept;
    assign w_ctl.load  = w_en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else begin
            if (w_en0) begin
                r_v0 <= i_smp.valid;
            end
            if (w_en1) begin
                r_v1 <= r_v0;
            end
        end
    end

    assign w_chain[0] = t_smp'{re: i_smp.sample_re, im: i_smp.sample_im};

    for (genvar k = 0; k < NUM_TAPS; k++) begin : g_cell
        if (k < NUM_TAPS - 1) begin : g_mid
            cfir_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl),
                .i_tap   (r_tap[k]),
                .i_smp   (w_chain[k]),
                .o_smp   (w_chain[k+1]),
                .o_prod  (w_prod[k])
            );
        end else begin : g_last
            cfir_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl),
                .i_tap   (r_tap[k]),
                .i_smp   (w_chain[k]),
                .o_smp   (),
                .o_prod  (w_prod[k])
            );
        end
    end

    cfir_tree u_tree (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_prod  (w_prod),
        .i_vld   (r_v1),
        .i_take  (w_en_out),
        .o_ready (w_tree_ready),
        .o_vld   (w_tree_vld),
        .o_sum   (w_sum)
    );

    assign w_res_re = round_sat(w_sum.re);
    assign w_res_im = round_sat(w_sum.im);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en_out) begin
            r_out_vld <= w_tree_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_out) begin
            r_out_re  <= w_res_re[SAMPLE_WIDTH-1:0];
            r_out_im  <= w_res_im[SAMPLE_WIDTH-1:0];
            r_out_sat <= w_res_re[SAMPLE_WIDTH] | w_res_im[SAMPLE_WIDTH];
        end
    end

    assign o_flt.valid       = r_out_vld;
    assign o_flt.filtered_re = r_out_re;
    assign o_flt.filtered_im = r_out_im;
    assign o_flt.saturated   = r_out_sat;

endmodule

// ===== src/cfir_checker.sv =====
// ----------------------------------------------------------------------------
// Complex FIR matched filter checker
// Port-level properties of the filter, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "complex_fir_matched_filter_macros.svh"

module cfir_checker import cfir_pkg::*; (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           i_in_ready,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic signed [SAMPLE_WIDTH-1:0] i_out_re,
    input logic signed [SAMPLE_WIDTH-1:0] i_out_im,
    input logic                           i_out_sat
);

    localparam int CNT_W = $clog2(PIPE_STAGES + 1) + 1;
    localparam logic signed [SAMPLE_WIDTH-1:0] SAT_HI = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] SAT_LO = ~SAT_HI;

    logic [CNT_W-1:0] r_inflight;
    logic [CNT_W-1:0] n_inflight;

    // count transactions between input acceptance and output delivery
    always_comb begin
        n_inflight = r_inflight;
        if (i_in_valid && i_in_ready) begin
            n_inflight = n_inflight + CNT_W'(1);
        end
        if (i_out_valid && i_out_ready) begin
            n_inflight = n_inflight - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= n_inflight;
        end
    end

    `CFIR_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid, "output dropped while stalled")
    `CFIR_ASSERT_NEXT(a_out_stable, i_out_valid && !i_out_ready, $stable(i_out_re) && $stable(i_out_im) && $stable(i_out_sat), "output payload changed while stalled")
    `CFIR_ASSERT_SAME(a_sat_clip, i_out_valid && i_out_sat, i_out_re == SAT_HI || i_out_re == SAT_LO || i_out_im == SAT_HI || i_out_im == SAT_LO, "saturation flag without a clipped component")
    `CFIR_ASSERT_SAME(a_no_phantom, i_out_valid, r_inflight != '0, "output with no sample in flight")
    `CFIR_ASSERT_SAME(a_depth, 1'b1, r_inflight <= CNT_W'(PIPE_STAGES), "more samples in flight than pipeline stages")

endmodule

bind complex_fir_matched_filter cfir_checker u_cfir_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_smp.valid),
    .i_in_ready  (i_smp.ready),
    .i_out_valid (o_flt.valid),
    .i_out_ready (o_flt.ready),
    .i_out_re    (o_flt.filtered_re),
    .i_out_im    (o_flt.filtered_im),
    .i_out_sat   (o_flt.saturated)
);

// ===== tb/sv/complex_fir_matched_filter_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Complex FIR matched filter testbench
// Streams complex Q1.15 samples through the filter under several tap sets
// and flow-control patterns. Results are checked field by field against the
// table or a running FIR predictor mirroring rounding and saturation rules.
// ----------------------------------------------------------------------------
module complex_fir_matched_filter_tb;
    import cfir_pkg::*;

    localparam int PHASES         = 8;
    localparam int PHASE_SAMPLES  = 200;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 12;

    typedef enum logic [CFG_IDX_W-1:0] {
        TAP0_REG, TAP1_REG, TAP2_REG, TAP3_REG,
        TAP4_REG, TAP5_REG, TAP6_REG, TAP7_REG
    } t_tap_reg;

    typedef enum int {FLOW_FREE, FLOW_SRC_IDLE, FLOW_SNK_STALL, FLOW_BOTH} t_flow_mode;
    typedef enum int {ROW_TAP, ROW_SAMPLE} t_row_kind;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] re;
        logic signed [SAMPLE_WIDTH-1:0] im;
        logic                           clip;
    } t_flt_res;

    typedef struct {
        t_row_kind        kind;
        t_tap_reg         idx;
        logic [CFG_W-1:0] word;
        t_smp             x;
        bit               typed;
        t_flt_res         res;
    } t_dir_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 out_rdy = 1'b0;

    cfir_in_if  in_if ();
    cfir_out_if out_if ();

    assign out_if.ready = out_rdy;

    complex_fir_matched_filter dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_smp      (in_if),
        .o_flt      (out_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_tap       coeff       [NUM_TAPS];
    t_smp       sample_hist [NUM_TAPS-1];
    t_flt_res   pending_outputs [$];
    t_dir_row   directed_rows [$];
    t_flow_mode flow_mode = FLOW_FREE;
    int         n_in, n_out, n_clip, n_err, n_tap_writes;
    int         quiet_cycles;

    task automatic report_mismatch(string msg);
        n_err++;
        $display("mismatch at result %0d: %s", n_out, msg);
    endtask

    function automatic logic signed [SAMPLE_WIDTH-1:0] clamp_q15(longint v, inout logic hit);
        longint hi = (longint'(1) << (SAMPLE_WIDTH - 1)) - 1;
        longint lo = -(longint'(1) << (SAMPLE_WIDTH - 1));
        if (v > hi) begin
            hit = 1'b1;
            return hi[SAMPLE_WIDTH-1:0];
        end
        if (v < lo) begin
            hit = 1'b1;
            return lo[SAMPLE_WIDTH-1:0];
        end
        return v[SAMPLE_WIDTH-1:0];
    endfunction

    // Compute y[n] from the current taps and delay line, then shift x in.
    function automatic t_flt_res filter_step(t_smp x);
        longint   acc_re, acc_im, tr, ti, sr, si;
        t_smp     s;
        t_flt_res r;
        logic     hit;
        acc_re = 0;
        acc_im = 0;
        hit    = 1'b0;
        for (int k = 0; k < NUM_TAPS; k++) begin
            s  = (k == 0) ? x : sample_hist[k-1];
            tr = longint'($signed(coeff[k].re));
            ti = longint'($signed(coeff[k].im));
            sr = longint'($signed(s.re));
            si = longint'($signed(s.im));
            acc_re += tr * sr - ti * si;
            acc_im += tr * si + ti * sr;
        end
        r.re   = clamp_q15((acc_re + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS, hit);
        r.im   = clamp_q15((acc_im + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS, hit);
        r.clip = hit;
        for (int k = NUM_TAPS - 2; k > 0; k--)
            sample_hist[k] = sample_hist[k-1];
        if (NUM_TAPS > 1)
            sample_hist[0] = x;
        return r;
    endfunction

    function automatic void tab_tap(t_tap_reg idx, logic [CFG_W-1:0] w);
        t_dir_row row;
        row.kind = ROW_TAP;
        row.idx  = idx;
        row.word = w;
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    function automatic void tab_smp(int re, int im, bit typed = 1'b0,
                                    int ere = 0, int eim = 0, bit eclip = 1'b0);
        t_dir_row row;
        row.kind     = ROW_SAMPLE;
        row.x.re     = 16'(re);
        row.x.im     = 16'(im);
        row.typed    = typed;
        row.res.re   = 16'(ere);
        row.res.im   = 16'(eim);
        row.res.clip = eclip;
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    function automatic t_smp rand_sample();
        t_smp s;
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: s = $urandom;
            6: begin
                s.re = $urandom_range(1) ? 16'h7FFF : 16'h8000;
                s.im = $urandom_range(1) ? 16'h7FFF : 16'h8000;
            end
            7: begin
                s.re = 16'($urandom_range(0, 511) - 256);
                s.im = 16'($urandom_range(0, 511) - 256);
            end
            8: begin
                s.re = $urandom;
                s.im = '0;
            end
            default: s = $urandom_range(1) ? {16'h7FFF, 16'h8000} : {16'h8000, 16'h7FFF};
        endcase
        return s;
    endfunction

    function automatic logic [CFG_W-1:0] phase_tap(int p, int k, int hot);
        case (p)
            1: return 32'h8000_8000;
            2: return 32'h7FFF_7FFF;
            3: return $urandom_range(1) ? $urandom : '0;
            4: return {16'($urandom_range(0, 4095) - 2048), 16'($urandom_range(0, 4095) - 2048)};
            5: return k[0] ? 32'h8000_7FFF : 32'h7FFF_8000;
            7: return (k == hot) ? 32'h7FFF_0000 : '0;
            default: return $urandom;
        endcase
    endfunction

    task automatic write_tap(t_tap_reg idx, logic [CFG_W-1:0] w);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= w;
        @(posedge i_clk);
        coeff[idx] = w;
        n_tap_writes++;
    endtask

    // Hold the input and wait until every predicted output has arrived.
    task automatic wait_drained();
        in_if.valid <= 1'b0;
        do @(negedge i_clk); while (pending_outputs.size() != 0);
        @(posedge i_clk);
    endtask

    task automatic drive_sample(t_smp x, bit typed, t_flt_res typed_res);
        t_flt_res pred;
        int       pct;
        pct = (flow_mode == FLOW_SRC_IDLE) ? 60 : (flow_mode == FLOW_BOTH) ? 8 : 0;
        while ($urandom_range(99) < pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.sample_re <= x.re;
        in_if.sample_im <= x.im;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        pred = filter_step(x);
        pending_outputs.insert(pending_outputs.size(), typed ? typed_res : pred);
        n_in++;
    endtask

    always @(posedge i_clk) begin
        int pct;
        pct = (flow_mode == FLOW_SNK_STALL) ? 60 : (flow_mode == FLOW_BOTH) ? 8 : 0;
        out_rdy <= ($urandom_range(99) >= pct);
    end

    always @(posedge i_clk) begin
        t_flt_res want;
        if (i_rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            if (out_if.saturated === 1'b1)
                n_clip++;
            if (pending_outputs.size() == 0) begin
                report_mismatch($sformatf("unexpected result re=%0d im=%0d",
                                          out_if.filtered_re, out_if.filtered_im));
            end else begin
                want = pending_outputs.pop_front();
                if (out_if.filtered_re !== want.re)
                    report_mismatch($sformatf("filtered_re got %0d expected %0d",
                                              out_if.filtered_re, want.re));
                if (out_if.filtered_im !== want.im)
                    report_mismatch($sformatf("filtered_im got %0d expected %0d",
                                              out_if.filtered_im, want.im));
                if (out_if.saturated !== want.clip)
                    report_mismatch($sformatf("saturated got %b expected %b",
                                              out_if.saturated, want.clip));
            end
            n_out++;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)
            || i_cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles, %0d outputs pending",
                     quiet_cycles, pending_outputs.size());
            $display("[complex_fir_matched_filter] ERROR");
            $finish;
        end
    end

    initial begin
        bit       streaming;
        int       hot;
        t_flt_res none;

        none         = '0;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = '0;
        i_cfg_data   = '0;
        in_if.valid     = 1'b0;
        in_if.sample_re = '0;
        in_if.sample_im = '0;
        quiet_cycles = 0;
        for (int k = 0; k < NUM_TAPS; k++)
            coeff[k] = '0;
        for (int k = 0; k < NUM_TAPS - 1; k++)
            sample_hist[k] = '0;

        // Start-up: only the oldest tap is set, so the first outputs see
        // an all-zero delay line.
        tab_tap(TAP7_REG, 32'h4000_4000);
        tab_smp( 32767, -32768, 1'b1, 0, 0, 1'b0);
        tab_smp(-32768,  32767, 1'b1, 0, 0, 1'b0);
        tab_smp(     0,      0, 1'b1, 0, 0, 1'b0);
        tab_smp(     1,     -1, 1'b1, 0, 0, 1'b0);
        tab_smp( 32767,  32767, 1'b1, 0, 0, 1'b0);
        tab_smp(-32768, -32768, 1'b1, 0, 0, 1'b0);
        tab_smp( 12345, -12345, 1'b1, 0, 0, 1'b0);
        tab_smp(     0,      0);
        // Rounding of ties goes up, for both signs.
        tab_tap(TAP7_REG, 32'h0000_0000);
        tab_tap(TAP0_REG, 32'h0001_0000);
        tab_smp( 16384, 0, 1'b1,  1, 0, 1'b0);
        tab_smp(-16384, 0, 1'b1,  0, 0, 1'b0);
        tab_smp(-16385, 0, 1'b1, -1, 0, 1'b0);
        // Minus one times minus one overflows and clips.
        tab_tap(TAP0_REG, 32'h8000_0000);
        tab_smp(-32768,  0, 1'b1, 32767, 0, 1'b1);
        tab_smp( 32767, -1);
        // All taps at the extremes; the delay line is kept across the change.
        for (int k = 0; k < NUM_TAPS; k++)
            tab_tap(t_tap_reg'(k), 32'h7FFF_8000);
        tab_smp( 32767,  32767);
        tab_smp(-32768, -32768);
        tab_smp( 32767, -32768);
        tab_smp(-32768,  32767);
        tab_smp( 32767,  32767);
        tab_smp(-32768,      0);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        streaming = 1'b0;
        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_TAP) begin
                if (streaming)
                    wait_drained();
                streaming = 1'b0;
                write_tap(directed_rows[r].idx, directed_rows[r].word);
            end else begin
                i_cfg_we <= 1'b0;
                drive_sample(directed_rows[r].x, directed_rows[r].typed,
                             directed_rows[r].res);
                streaming = 1'b1;
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            hot = $urandom_range(NUM_TAPS - 1);
            for (int k = 0; k < NUM_TAPS; k++)
                write_tap(t_tap_reg'(k), phase_tap(p, k, hot));
            flow_mode <= t_flow_mode'(p % 4);
            for (int n = 0; n < PHASE_SAMPLES; n++) begin
                i_cfg_we <= 1'b0;
                drive_sample(rand_sample(), 1'b0, none);
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("run covered %0d samples and %0d outputs, %0d of them clipped,",
                 n_in, n_out, n_clip);
        $display("with %0d tap writes over %0d tap sets and four flow patterns",
                 n_tap_writes, PHASES + 4);
        if (n_err == 0) begin
            $display("[complex_fir_matched_filter] OK");
        end else begin
            $display("%0d mismatches", n_err);
            $display("[complex_fir_matched_filter] ERROR");
        end
        $finish;
    end

endmodule
